// ===== hw/rtl/ltmt_pkg.sv =====
// Package for the map tile locator: word layouts, fixed-point constants and ROM functions.
// Used by ltmt_circ_cell, ltmt_hyp_cell and latlon_to_map_tile.
package ltmt_pkg;

    localparam int MAX_ZOOM      = 20;
    localparam int FRAC          = 22;   // fraction bits of all angles and ratios
    localparam int CIRC_STAGES   = 24;
    localparam int HYP_STAGES    = 26;   // shifts 1..24 with 4 and 13 repeated
    localparam int CW            = 27;   // CORDIC datapath width

    localparam int LAT_W  = 30;
    localparam int LNG_W  = 31;
    localparam int ALT_W  = 17;
    localparam int COL_W  = 21;
    localparam int ROW_W  = 22;
    localparam int ZOOM_W = 5;
    localparam int MESH_W = 6;
    localparam int TAG_W  = 3;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] LN2_Q64    = 64'hB17217F7D1CF79AB;
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE60DB9391054A;
    localparam logic [63:0] GAIN_Q40   = 64'h0000009B74EDA843;

    // Degrees to radians at 38 fraction bits.
    localparam logic [32:0] D2R = 33'(((PI_Q60 / 180) + (64'd1 << 21)) >> 22);
    localparam logic signed [CW-1:0] C_PI     = CW'((PI_Q60 + (64'd1 << 37)) >> 38);
    localparam logic signed [CW-1:0] C_HALFPI = CW'((PI_Q60 + (64'd1 << 38)) >> 39);
    localparam logic signed [CW-1:0] C_GAIN   = CW'((GAIN_Q40 + (64'd1 << 17)) >> 18);
    localparam logic signed [CW-1:0] C_EMAX   = CW'((64'd9999 << FRAC) / 10000);
    localparam logic signed [CW-1:0] C_ONE    = CW'(64'd1 << FRAC);
    localparam logic signed [27:0]   C_LN2H   = 28'((LN2_Q64 + (64'd1 << 42)) >> 43);
    localparam logic [39:0] C_INV2PI = 40'((INV2PI_Q64 + (64'd1 << 23)) >> 24);
    localparam logic signed [47:0] INV_LO = 48'(C_INV2PI[18:0]);
    localparam logic signed [47:0] INV_HI = 48'(C_INV2PI[39:19]);

    // Column: floor(u / 45) through a reciprocal, u biased to stay non-negative.
    localparam logic [28:0] COL_RECIP = 29'((64'd1 << 34) / 45);
    localparam int          COL_BIAS  = 45 * (1 << 18);

    typedef struct packed {
        logic [ZOOM_W-1:0] zoom;
        logic [COL_W-1:0]  col;
        logic signed [5:0] dsh;   // sq - sp from the normalization
    } t_side;

    function automatic logic [63:0] series(input int i, input bit alternating);
        logic [63:0] sum;
        logic [63:0] term;
        int          ex;
        sum = 64'd0;
        for (int k = 0; k < 31; k++) begin
            ex = i * (2 * k + 1);
            if (ex <= 60) begin
                term = (64'd1 << (60 - ex)) / 64'(2 * k + 1);
                if (alternating && k[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    function automatic logic signed [CW-1:0] atan_q(input int i);
        logic [63:0] a;
        a = (i == 0) ? (PI_Q60 >> 2) : series(i, 1'b1);
        return CW'((a + (64'd1 << 37)) >> 38);
    endfunction

    function automatic logic signed [CW-1:0] atanh_q(input int i);
        logic [63:0] h;
        h = series(i, 1'b0);
        return CW'((h + (64'd1 << 37)) >> 38);
    endfunction

    // Shift of hyperbolic stage k: 1,2,3,4,4,5,...,13,13,14,...,24.
    function automatic int hyp_shift(input int k);
        int s;
        s = k + 1;
        if (k >= 4) begin
            s = k;
        end
        if (k >= 14) begin
            s = k - 1;
        end
        return s;
    endfunction

    // Left shift that brings a non-zero 23-bit value into [2^22, 2^23).
    function automatic logic [4:0] norm_shift(input logic [FRAC:0] v);
        logic [4:0] s;
        s = 5'd0;
        for (int b = 0; b <= FRAC; b++) begin
            if (v[b]) begin
                s = 5'(FRAC - b);
            end
        end
        return s;
    endfunction

    function automatic logic [MESH_W-1:0] mesh_div(input logic [ZOOM_W-1:0] z);
        logic [MESH_W-1:0] m;
        case (z)
            5'd8, 5'd9:                 m = 6'd32;
            5'd10, 5'd11:               m = 6'd16;
            5'd12, 5'd13, 5'd14:        m = 6'd8;
            5'd15, 5'd16, 5'd17, 5'd18: m = 6'd4;
            5'd19:                      m = 6'd2;
            default:                    m = 6'd1;
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/ltmt_circ_cell.sv =====
// One rotation stage of the circular CORDIC that turns latitude into its sine.
// Depends on ltmt_pkg for widths and the side-data struct.
module ltmt_circ_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [4:0]                      i_shift,
    input  logic signed [ltmt_pkg::CW-1:0]  i_angle,
    input  logic                            i_valid,
    input  logic signed [ltmt_pkg::CW-1:0]  i_x,
    input  logic signed [ltmt_pkg::CW-1:0]  i_y,
    input  logic signed [ltmt_pkg::CW-1:0]  i_z,
    input  ltmt_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic signed [ltmt_pkg::CW-1:0]  o_x,
    output logic signed [ltmt_pkg::CW-1:0]  o_y,
    output logic signed [ltmt_pkg::CW-1:0]  o_z,
    output ltmt_pkg::t_side                 o_side
);

    logic                           r_valid;
    logic signed [ltmt_pkg::CW-1:0] r_x, r_y, r_z;
    ltmt_pkg::t_side                r_side;
    logic signed [ltmt_pkg::CW-1:0] n_x, n_y, n_z;
    logic signed [ltmt_pkg::CW-1:0] dx, dy;

    always_comb begin
        dx = i_y >>> i_shift;
        dy = i_x >>> i_shift;
        if (!i_z[ltmt_pkg::CW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - i_angle;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/ltmt_hyp_cell.sv =====
// One vectoring stage of the hyperbolic CORDIC that accumulates atanh of the sine.
// Depends on ltmt_pkg for widths and the side-data struct.
module ltmt_hyp_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [4:0]                      i_shift,
    input  logic signed [ltmt_pkg::CW-1:0]  i_angle,
    input  logic                            i_valid,
    input  logic signed [ltmt_pkg::CW-1:0]  i_x,
    input  logic signed [ltmt_pkg::CW-1:0]  i_y,
    input  logic signed [ltmt_pkg::CW-1:0]  i_z,
    input  ltmt_pkg::t_side                 i_side,
    output logic                            o_valid,
    output logic signed [ltmt_pkg::CW-1:0]  o_x,
    output logic signed [ltmt_pkg::CW-1:0]  o_y,
    output logic signed [ltmt_pkg::CW-1:0]  o_z,
    output ltmt_pkg::t_side                 o_side
);

    logic                           r_valid;
    logic signed [ltmt_pkg::CW-1:0] r_x, r_y, r_z;
    ltmt_pkg::t_side                r_side;
    logic signed [ltmt_pkg::CW-1:0] n_x, n_y, n_z;
    logic signed [ltmt_pkg::CW-1:0] dx, dy;

    always_comb begin
        dx = i_y >>> i_shift;
        dy = i_x >>> i_shift;
        // Drive y toward zero.
        if (!i_y[ltmt_pkg::CW-1]) begin
            n_x = i_x - dx;
            n_y = i_y - dy;
            n_z = i_z + i_angle;
        end else begin
            n_x = i_x + dx;
            n_y = i_y + dy;
            n_z = i_z - i_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/latlon_to_map_tile.sv =====
// Top level of the map tile locator: front stages, two CORDIC cell chains, back stages.
// Depends on ltmt_pkg, ltmt_circ_cell and ltmt_hyp_cell.
//
// Usage:
// The slave stream carries one geographic point per word: latitude and longitude in
// degrees with 22 fraction bits, and altitude in metres (negative gives the zoom).
// The master stream returns one word per point: tile column and row at the chosen
// zoom, the zoom, the terrain mesh divisions and the server tag length.
// The datapath is a 60-stage pipeline: 4 front stages (radians, zoom, column
// division), 24 circular CORDIC cells, 2 normalization stages, 26 hyperbolic cells
// and 4 back stages ending in the output register. One word
// is accepted every cycle while the output is taken.
// The whole pipeline advances together; when the receiver stalls with a word waiting
// in the output register, o_s_tready drops and every stage holds, so no word is lost.
// Synchronous active-low reset empties the pipeline; there is no other state.
module latlon_to_map_tile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [29:0] latitude, [60:30] longitude, [77:61] altitude, [79:78] zero
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [20:0] tile_column, [42:21] tile_row, [47:43] zoom_level,
    // [53:48] mesh_divisions, [56:54] server_tag_len, [63:57] zero
    output logic [63:0] o_m_tdata
);

    localparam int CW = ltmt_pkg::CW;
    localparam int NC = ltmt_pkg::CIRC_STAGES;
    localparam int NH = ltmt_pkg::HYP_STAGES;

    logic w_en;

    // Front stage registers.
    logic [3:0]                     r_fv;
    logic signed [63:0]             r1_prod;
    logic signed [32:0]             r1_v;
    logic [4:0]                     r1_zoom;
    logic signed [CW-1:0]           r2_th, r3_th, r4_th;
    logic [26:0]                    r2_u, r3_u;
    logic [55:0]                    r3_m;
    logic [4:0]                     r2_zoom, r3_zoom;
    ltmt_pkg::t_side                r4_side;

    logic signed [63:0]             n1_prod;
    logic signed [32:0]             n1_v;
    logic [4:0]                     n1_zoom;
    logic signed [29:0]             w_lat;
    logic signed [16:0]             w_alt;
    logic [16:0]                    w_nalt;
    logic [23:0]                    w_kq;
    logic signed [CW-1:0]           n2_th, w_th_raw;
    logic signed [53:0]             w_vz;
    logic signed [28:0]             w_w;
    logic [26:0]                    n2_u;
    logic [21:0]                    w_q0, w_q;
    logic [27:0]                    w_rem;

    // CORDIC chains.
    logic                 c_v [NC+1];
    logic signed [CW-1:0] c_x [NC+1];
    logic signed [CW-1:0] c_y [NC+1];
    logic signed [CW-1:0] c_z [NC+1];
    ltmt_pkg::t_side      c_s [NC+1];
    logic                 h_v [NH+1];
    logic signed [CW-1:0] h_x [NH+1];
    logic signed [CW-1:0] h_y [NH+1];
    logic signed [CW-1:0] h_z [NH+1];
    ltmt_pkg::t_side      h_s [NH+1];

    // Normalization and back stage registers.
    logic [1:0]           r_nv;
    logic [3:0]           r_bv;
    logic [22:0]          r_np, r_nq;
    ltmt_pkg::t_side      r_nside, r_b1side, r_b2side, r_b3side;
    logic signed [CW-1:0] w_e;
    logic signed [CW-1:0] w_pn, w_qn;
    logic [4:0]           w_sp, w_sq;
    logic signed [27:0]   r_a, n_a, w_dsh;
    logic signed [47:0]   r_pl, r_ph, w_ax;
    logic signed [63:0]   r_d, n_d;
    logic [5:0]           w_sh;
    logic signed [63:0]   w_rowf;
    logic [21:0]          w_row;
    logic [63:0]          r_out, n_out;

    assign w_en       = !r_bv[3] || i_m_tready;
    assign o_s_tready = w_en;

    // Stage 1: radians product, zoom from altitude, offset longitude.
    always_comb begin
        w_lat   = $signed(i_s_tdata[29:0]);
        w_alt   = $signed(i_s_tdata[77:61]);
        n1_prod = 64'(w_lat) * $signed(64'(ltmt_pkg::D2R));
        n1_v    = 33'($signed(i_s_tdata[60:30])) + 33'sd754974720;
        w_nalt  = 17'(-w_alt);
        // floor(alt/100) for alt below 2000 by reciprocal multiply.
        w_kq    = (24'(w_alt[10:0]) * 24'd5243) >> 19;
        if (w_alt[16]) begin
            n1_zoom = (w_nalt > 17'(ltmt_pkg::MAX_ZOOM)) ? 5'(ltmt_pkg::MAX_ZOOM)
                                                        : w_nalt[4:0];
        end else if (w_alt >= 17'sd2000) begin
            n1_zoom = 5'd0;
        end else begin
            n1_zoom = 5'(ltmt_pkg::MAX_ZOOM) - w_kq[4:0];
        end
    end

    // Stage 2: fold the angle into [-pi/2, pi/2], scale longitude by 2^zoom.
    always_comb begin
        w_th_raw = CW'(r1_prod >>> 38);
        if (w_th_raw > ltmt_pkg::C_HALFPI) begin
            n2_th = ltmt_pkg::C_PI - w_th_raw;
        end else if (w_th_raw < -ltmt_pkg::C_HALFPI) begin
            n2_th = -ltmt_pkg::C_PI - w_th_raw;
        end else begin
            n2_th = w_th_raw;
        end
        w_vz = 54'(r1_v) <<< r1_zoom;
        w_w  = w_vz[53:25];
        n2_u = 27'(w_w + 29'(ltmt_pkg::COL_BIAS));
    end

    // Stage 4: correct the reciprocal quotient by one where needed.
    always_comb begin
        w_q0  = r3_m[55:34];
        w_rem = 28'(r3_u) - (28'(w_q0) * 28'd45);
        w_q   = (w_rem >= 28'd45) ? (w_q0 + 22'd1) : w_q0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_prod <= n1_prod;
            r1_v    <= n1_v;
            r1_zoom <= n1_zoom;
            r2_th   <= n2_th;
            r2_u    <= n2_u;
            r2_zoom <= r1_zoom;
            r3_th   <= r2_th;
            r3_u    <= r2_u;
            r3_m    <= 56'(r2_u) * 56'(ltmt_pkg::COL_RECIP);
            r3_zoom <= r2_zoom;
            r4_th   <= r3_th;
            r4_side.zoom <= r3_zoom;
            r4_side.col  <= 21'(w_q - 22'd262144);
            r4_side.dsh  <= 6'sd0;
        end
    end

    assign c_v[0] = r_fv[3];
    assign c_x[0] = ltmt_pkg::C_GAIN;
    assign c_y[0] = '0;
    assign c_z[0] = r4_th;
    assign c_s[0] = r4_side;

    for (genvar k = 0; k < NC; k++) begin : g_circ
        ltmt_circ_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (5'(k)),
            .i_angle (ltmt_pkg::atan_q(k)),
            .i_valid (c_v[k]),
            .i_x     (c_x[k]),
            .i_y     (c_y[k]),
            .i_z     (c_z[k]),
            .i_side  (c_s[k]),
            .o_valid (c_v[k+1]),
            .o_x     (c_x[k+1]),
            .o_y     (c_y[k+1]),
            .o_z     (c_z[k+1]),
            .o_side  (c_s[k+1])
        );
    end

    // Clamp the sine and form p = 1+e, q = 1-e.
    always_comb begin
        w_e = c_y[NC];
        if (w_e > ltmt_pkg::C_EMAX) begin
            w_e = ltmt_pkg::C_EMAX;
        end else if (w_e < -ltmt_pkg::C_EMAX) begin
            w_e = -ltmt_pkg::C_EMAX;
        end
    end

    always_comb begin
        w_sp = ltmt_pkg::norm_shift(r_np);
        w_sq = ltmt_pkg::norm_shift(r_nq);
        w_pn = CW'(r_np << w_sp);
        w_qn = CW'(r_nq << w_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv <= '0;
        end else if (w_en) begin
            r_nv <= {r_nv[0], c_v[NC]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_np    <= 23'(ltmt_pkg::C_ONE + w_e);
            r_nq    <= 23'(ltmt_pkg::C_ONE - w_e);
            r_nside <= c_s[NC];
            h_x[0]  <= w_pn + w_qn;
            h_y[0]  <= w_pn - w_qn;
            h_s[0].zoom <= r_nside.zoom;
            h_s[0].col  <= r_nside.col;
            h_s[0].dsh  <= $signed(6'(w_sq)) - $signed(6'(w_sp));
        end
    end

    assign h_v[0] = r_nv[1];
    assign h_z[0] = '0;

    for (genvar k = 0; k < NH; k++) begin : g_hyp
        ltmt_hyp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_shift (5'(ltmt_pkg::hyp_shift(k))),
            .i_angle (ltmt_pkg::atanh_q(ltmt_pkg::hyp_shift(k))),
            .i_valid (h_v[k]),
            .i_x     (h_x[k]),
            .i_y     (h_y[k]),
            .i_z     (h_z[k]),
            .i_side  (h_s[k]),
            .o_valid (h_v[k+1]),
            .o_x     (h_x[k+1]),
            .o_y     (h_y[k+1]),
            .o_z     (h_z[k+1]),
            .o_side  (h_s[k+1])
        );
    end

    // Back stages: add the ln2/2 correction, scale by 1/(2pi), shift to the zoom.
    always_comb begin
        w_dsh = 28'(h_s[NH].dsh);
        n_a   = 28'(h_z[NH]) + w_dsh * ltmt_pkg::C_LN2H;
        w_ax  = 48'(r_a);
        n_d   = (64'sd1 <<< 61) - ((64'(r_ph) <<< 19) + 64'(r_pl));
        w_sh  = 6'd62 - 6'(r_b3side.zoom);
        w_rowf = r_d >>> w_sh;
        w_row  = w_rowf[21:0];
        n_out  = {7'd0,
                  3'(3 * r_b3side.col[2:0] + w_row[2:0]),
                  ltmt_pkg::mesh_div(r_b3side.zoom),
                  r_b3side.zoom,
                  w_row,
                  r_b3side.col};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (w_en) begin
            r_bv <= {r_bv[2:0], h_v[NH]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a      <= n_a;
            r_b1side <= h_s[NH];
            r_pl     <= w_ax * ltmt_pkg::INV_LO;
            r_ph     <= w_ax * ltmt_pkg::INV_HI;
            r_b2side <= r_b1side;
            r_d      <= n_d;
            r_b3side <= r_b2side;
            r_out    <= n_out;
        end
    end

    assign o_m_tvalid = r_bv[3];
    assign o_m_tdata  = r_out;

endmodule

// ===== hw/rtl/ltmt_checker.sv =====
// Port-level checker for the map tile locator, bound to latlon_to_map_tile.
// Depends on the top level's port list only.
module ltmt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [79:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed while stalled");

    // The input side is ready exactly when the output register can move.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow the output stall");

    a_zoom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[47:43] <= 5'd20) && (o_m_tdata[53:48] != 6'd0)
                       && (o_m_tdata[53:48] <= 6'd32))
        else $error("zoom or mesh divisions out of range");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result word present after reset");

endmodule

bind latlon_to_map_tile ltmt_checker u_ltmt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
